/* design/multi_waveform_oscillator_top_assert.svh */
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_top_assert.svh
// Assertion macros for the oscillator RTL; sampled on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_OSCILLATOR_TOP_ASSERT_SVH
`define MULTI_WAVEFORM_OSCILLATOR_TOP_ASSERT_SVH

// property must hold at every edge out of reset
`define MWO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define MWO_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants for the multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int PHASE_BITS   = 24;
    localparam int PHASE_W      = 24;
    localparam int SAMPLE_W     = 26;
    localparam int HORNER_STEPS = 6;

    // pipeline timing: sine path sets the depth, one mux stage at the end
    localparam int SINE_LAT   = 3 + 3 * HORNER_STEPS + 2;
    localparam int NOISE_LAT  = 9;
    localparam int PIPE_DEPTH = SINE_LAT + 1;

    localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D0_49BB_1331_11EB;
    localparam logic [32:0] PI_Q31     = 33'd6746518852;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [SAMPLE_W-1:0] ONE_Q24 = SAMPLE_W'(16777216);

    // horner divisors and their floor(2^32 / k) reciprocals
    localparam logic [63:0] RECIP_BASE = 64'd1 << 32;
    localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] =
        '{32'(RECIP_BASE / 64'd156), 32'(RECIP_BASE / 64'd110),
          32'(RECIP_BASE / 64'd72),  32'(RECIP_BASE / 64'd42),
          32'(RECIP_BASE / 64'd20),  32'(RECIP_BASE / 64'd6)};

    typedef enum logic [2:0] {
        OP_SINE     = 3'd0,
        OP_SAW      = 3'd1,
        OP_SQUARE   = 3'd2,
        OP_TRIANGLE = 3'd3,
        OP_NOISE    = 3'd4
    } opcode_t;

    // values that ride alongside the horner chain
    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic [1:0]  quad;
    } sine_side_t;

endpackage

/* design/mwo_mul64_lo.sv */
// ----------------------------------------------------------------------------
// mwo_mul64_lo
// Two-stage low-half 64x64 multiply: 32-bit partial products, then the sum.
// ----------------------------------------------------------------------------
module mwo_mul64_lo (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);
    logic [63:0] ll_reg;
    logic [63:0] ll_next;
    logic [31:0] lh_reg;
    logic [31:0] lh_next;
    logic [31:0] hl_reg;
    logic [31:0] hl_next;
    logic [63:0] p_reg;
    logic [63:0] p_next;

    // partial products, cross terms only need their low half
    always_comb
    begin
        ll_next = 64'(a[31:0]) * 64'(b[31:0]);
        lh_next = 32'(a[31:0] * b[63:32]);
        hl_next = 32'(a[63:32] * b[31:0]);
    end

    // recombine
    always_comb
    begin
        p_next = ll_reg + {32'(lh_reg + hl_reg), 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* design/mwo_noise.sv */
// ----------------------------------------------------------------------------
// mwo_noise
// SplitMix64 noise pipeline, delayed to line up with the sine path.
// ----------------------------------------------------------------------------
module mwo_noise (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] seed,
    input  logic [63:0] position,
    output logic [23:0] noise_u
);
    import mwo_pkg::*;

    localparam int PAD = SINE_LAT - NOISE_LAT;

    logic [63:0] m;
    logic [63:0] w;
    logic [63:0] v;
    logic [63:0] z;
    logic [63:0] y_reg;
    logic [63:0] y_next;
    logic [63:0] w_reg;
    logic [63:0] w_next;
    logic [63:0] zf;
    logic [23:0] u_reg;
    logic [23:0] u_next;
    logic [23:0] pad_reg [PAD];

    // position times golden increment
    mwo_mul64_lo u_mul_pos (.clk(clk), .en(en), .a(position), .b(GOLDEN_INC), .p(m));

    // seed, first increment and first xor-shift
    always_comb
    begin
        z      = (seed ^ m) + GOLDEN_INC;
        y_next = z ^ (z >> 30);
    end

    mwo_mul64_lo u_mul_c1 (.clk(clk), .en(en), .a(y_reg), .b(MIX_C1), .p(w));

    always_comb
    begin
        w_next = w ^ (w >> 27);
    end

    mwo_mul64_lo u_mul_c2 (.clk(clk), .en(en), .a(w_reg), .b(MIX_C2), .p(v));

    // final xor-shift, keep the top 24 bits
    always_comb
    begin
        zf     = v ^ (v >> 31);
        u_next = zf[63:40];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
            w_reg <= w_next;
            u_reg <= u_next;
            pad_reg[0] <= u_reg;
            for (int i = 1; i < PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign noise_u = pad_reg[PAD-1];

endmodule

/* design/mwo_horner_step.sv */
// ----------------------------------------------------------------------------
// mwo_horner_step
// One Horner step t' = 2^30 - ((x2*t) >> 30) / k over three stages.
// ----------------------------------------------------------------------------
module mwo_horner_step (
    input  logic                clk,
    input  logic                en,
    input  mwo_pkg::sine_side_t side_in,
    input  logic [30:0]         t_in,
    input  logic [7:0]          div,
    input  logic [31:0]         recip,
    output mwo_pkg::sine_side_t side_out,
    output logic [30:0]         t_out
);
    import mwo_pkg::*;

    sine_side_t  side_a_reg;
    sine_side_t  side_b_reg;
    sine_side_t  side_c_reg;
    logic [62:0] prod_a_reg;
    logic [62:0] prod_a_next;
    logic [31:0] v_b_reg;
    logic [31:0] v_b_next;
    logic [61:0] qp_b_reg;
    logic [61:0] qp_b_next;
    logic [30:0] t_c_reg;
    logic [30:0] t_c_next;
    logic [29:0] q_est;
    logic [31:0] rem;
    logic [30:0] q;

    // x2 times t
    always_comb
    begin
        prod_a_next = 63'(side_in.x2) * 63'(t_in);
    end

    // scale and multiply by the reciprocal
    always_comb
    begin
        v_b_next  = prod_a_reg[61:30];
        qp_b_next = 62'(v_b_next) * 62'(recip);
    end

    // quotient estimate is at most one short: fix it, then subtract from one
    always_comb
    begin
        q_est    = qp_b_reg[61:32];
        rem      = v_b_reg - 32'(32'(q_est) * 32'(div));
        q        = 31'(q_est) + ((rem >= 32'(div)) ? 31'd1 : 31'd0);
        t_c_next = ONE_Q30 - q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg <= side_in;
            prod_a_reg <= prod_a_next;
            side_b_reg <= side_a_reg;
            v_b_reg    <= v_b_next;
            qp_b_reg   <= qp_b_next;
            side_c_reg <= side_b_reg;
            t_c_reg    <= t_c_next;
        end
    end

    assign side_out = side_c_reg;
    assign t_out    = t_c_reg;

endmodule

/* design/mwo_sine.sv */
// ----------------------------------------------------------------------------
// mwo_sine
// Fixed-point sine: quadrant fold, angle scale, Taylor series by Horner.
// ----------------------------------------------------------------------------
module mwo_sine (
    input  logic                               clk,
    input  logic                               en,
    input  logic [mwo_pkg::PHASE_W-1:0]        phase,
    output logic signed [mwo_pkg::SAMPLE_W-1:0] sine_q24
);
    import mwo_pkg::*;

    logic [31:0]       p;
    logic [1:0]        quad;
    logic [30:0]       rf;
    logic [63:0]       ang_reg;
    logic [63:0]       ang_next;
    logic [1:0]        quad1_reg;
    logic [30:0]       x2x_reg;
    logic [30:0]       x2x_next;
    logic [61:0]       sq_reg;
    logic [61:0]       sq_next;
    logic [1:0]        quad2_reg;
    sine_side_t        side0_reg;
    sine_side_t        side0_next;
    sine_side_t        side_chain [HORNER_STEPS+1];
    logic [30:0]       t_chain [HORNER_STEPS+1];
    logic [61:0]       sprod_reg;
    logic [61:0]       sprod_next;
    logic [1:0]        quadf_reg;
    logic [31:0]       s;
    logic [26:0]       vr;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] out_reg;
    logic [SAMPLE_W-1:0] out_next;

    // fold into the first quadrant and scale to an angle
    always_comb
    begin
        p        = 32'(phase[PHASE_BITS-1:0]) << (32 - PHASE_BITS);
        quad     = p[31:30];
        rf       = quad[0] ? (ONE_Q30 - 31'(p[29:0])) : 31'(p[29:0]);
        ang_next = 64'(rf) * 64'(PI_Q31);
    end

    // x and x squared
    always_comb
    begin
        x2x_next = ang_reg[62:32];
        sq_next  = 62'(x2x_next) * 62'(x2x_next);
    end

    always_comb
    begin
        side0_next.x    = x2x_reg;
        side0_next.x2   = sq_reg[61:30];
        side0_next.quad = quad2_reg;
    end

    assign side_chain[0] = side0_reg;
    assign t_chain[0]    = ONE_Q30;

    // horner chain, innermost term first
    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_horner
        mwo_horner_step u_step (
            .clk      (clk),
            .en       (en),
            .side_in  (side_chain[i]),
            .t_in     (t_chain[i]),
            .div      (HORNER_DIV[i]),
            .recip    (HORNER_RECIP[i]),
            .side_out (side_chain[i+1]),
            .t_out    (t_chain[i+1])
        );
    end

    // x times the series
    always_comb
    begin
        sprod_next = 62'(side_chain[HORNER_STEPS].x) * 62'(t_chain[HORNER_STEPS]);
    end

    // round to q24, saturate at one, sign by quadrant
    always_comb
    begin
        s   = sprod_reg[61:30];
        vr  = 27'((33'(s) + 33'd32) >> 6);
        mag = (vr > 27'(ONE_Q24)) ? ONE_Q24 : SAMPLE_W'(vr);
        out_next = quadf_reg[1] ? (SAMPLE_W'(0) - mag) : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg   <= ang_next;
            quad1_reg <= quad;
            x2x_reg   <= x2x_next;
            sq_reg    <= sq_next;
            quad2_reg <= quad1_reg;
            side0_reg <= side0_next;
            sprod_reg <= sprod_next;
            quadf_reg <= side_chain[HORNER_STEPS].quad;
            out_reg   <= out_next;
        end
    end

    assign sine_q24 = out_reg;

endmodule

/* design/multi_waveform_oscillator_top.sv */
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_top
// Sine, saw, square, triangle and SplitMix64 noise sample generator.
// ----------------------------------------------------------------------------
// One sample per beat, 24 fractional bits. The block takes one beat per
// cycle unless stalled and returns each sample, in order, from the final
// mux register; the depth is set by the sine path (angle multiply, six
// three-stage Horner steps, final multiply and rounding). The whole pipeline
// stalls together while the output beat waits. seed_reg is written through cfg_we/cfg_wdata.
`include "multi_waveform_oscillator_top_assert.svh"

module multi_waveform_oscillator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [63:0]                         cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          opcode,
    input  logic [mwo_pkg::PHASE_W-1:0]         phase,
    input  logic [63:0]                         position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mwo_pkg::SAMPLE_W-1:0] sample
);
    import mwo_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    logic                en;
    logic [63:0]         seed_reg;
    logic                vld_reg [PIPE_DEPTH];
    logic [2:0]          op_reg [PIPE_DEPTH];
    logic [PHASE_W-1:0]  ph_reg [LAST];
    logic signed [SAMPLE_W-1:0] sine_q24;
    logic [23:0]         noise_u;
    logic [31:0]         p;
    logic [25:0]         f;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;

    // pipeline moves unless the output beat is stuck
    assign en       = !vld_reg[LAST] || out_ready;
    assign in_ready = en;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // opcode and phase ride along
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0] <= opcode;
            ph_reg[0] <= phase;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                op_reg[i] <= op_reg[i-1];
            end
            for (int i = 1; i < LAST; i++)
            begin
                ph_reg[i] <= ph_reg[i-1];
            end
            sample_reg <= sample_next;
        end
    end

    mwo_sine u_sine (
        .clk      (clk),
        .en       (en),
        .phase    (phase),
        .sine_q24 (sine_q24)
    );

    mwo_noise u_noise (
        .clk      (clk),
        .en       (en),
        .seed     (seed_reg),
        .position (position),
        .noise_u  (noise_u)
    );

    // waveform select
    always_comb
    begin
        p = 32'(ph_reg[LAST-1][PHASE_BITS-1:0]) << (32 - PHASE_BITS);
        f = p[31:6];
        case (op_reg[LAST-1])
            OP_SINE:     sample_next = sine_q24;
            OP_SAW:      sample_next = SAMPLE_W'(p[31:7]) - ONE_Q24;
            OP_SQUARE:   sample_next = p[31] ? (SAMPLE_W'(0) - ONE_Q24) : ONE_Q24;
            OP_TRIANGLE: sample_next = p[31] ? (SAMPLE_W'(50331648) - f)
                                             : (f - ONE_Q24);
            OP_NOISE:    sample_next = SAMPLE_W'({noise_u, 1'b0}) - ONE_Q24;
            default:     sample_next = '0;
        endcase
    end

    assign out_valid = vld_reg[LAST];
    assign sample    = sample_reg;

    // checks
    `MWO_ASSERT(a_accept_enters, (in_valid && in_ready) |=> vld_reg[0], "accepted beat lost at entry")
    `MWO_ASSERT(a_range, out_valid |-> ($signed(sample) <= 26'sd16777216 && $signed(sample) >= -26'sd16777216), "sample out of range")
    `MWO_ASSERT(a_silence, (out_valid && op_reg[LAST] > OP_NOISE) |-> (sample == '0), "silence gave nonzero")
    `MWO_ASSERT_NEVER(a_square_level, out_valid && op_reg[LAST] == OP_SQUARE && sample != ONE_Q24 && sample != (SAMPLE_W'(0) - ONE_Q24), "square not at full scale")

endmodule

/* tb/multi_waveform_oscillator_top_test.sv */
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_top_test
// Self-checking bench for the multi-waveform oscillator sample generator.
// ----------------------------------------------------------------------------
// A directed table covers the waveform extremes and the silent opcodes, then
// random beats run under several noise seeds. Each accepted beat is scored
// by a bit-exact integer model of the waveforms and the SplitMix64 noise.
// The sender works in bursts and the receiver stalls on its own pattern.
module multi_waveform_oscillator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mwo_pkg::*;

    localparam logic [2:0] OP_MUTE_LO  = 3'd5;
    localparam logic [2:0] OP_MUTE_MID = 3'd6;
    localparam logic [2:0] OP_MUTE_HI  = 3'd7;
    localparam int         TAIL_CYC    = PIPE_DEPTH + 8;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RAND_BEATS  = 160;
    localparam logic [25:0] PLUS_ONE   = 26'h100_0000;
    localparam logic [25:0] MINUS_ONE  = 26'h300_0000;

    typedef struct {
        logic [2:0]  op;
        logic [23:0] ph;
        logic [63:0] pos;
        bit          known;
        logic [25:0] want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [23:0] phase = '0;
    logic [63:0] position = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;

    logic [25:0] samples_due[$];
    logic [63:0] seed_copy = '0;
    int          fail_count = 0;
    int          cycle_count = 0;

    multi_waveform_oscillator_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .phase(phase), .position(position), .out_valid(out_valid),
        .out_ready(out_ready), .sample(sample)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sine by taylor series in unsigned q30, all products modulo 2^64
    function automatic logic [63:0] sine_mag(logic [31:0] p);
        logic [63:0] r, x, x2, t, s, v;
        logic [63:0] divs [6];
        divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        r = {34'd0, p[29:0]};
        if (p[30])
            r = 64'd1073741824 - r;
        x  = (r * 64'(PI_Q31)) >> 32;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        for (int k = 0; k < 6; k++)
            t = 64'd1073741824 - ((x2 * t) >> 30) / divs[k];
        s = (x * t) >> 30;
        v = (s + 64'd32) >> 6;
        if (v > 64'd16777216)
            v = 64'd16777216;
        return v;
    endfunction

    // splitmix64 output for this position, top 24 bits scaled to +-1
    function automatic logic [63:0] noise_val(logic [63:0] pos, logic [63:0] seed);
        logic [63:0] z;
        z = seed ^ (pos * GOLDEN_INC);
        z = z + GOLDEN_INC;
        z = (z ^ (z >> 30)) * MIX_C1;
        z = (z ^ (z >> 27)) * MIX_C2;
        z = z ^ (z >> 31);
        return 64'(2 * (z >> 40)) - 64'd16777216;
    endfunction

    function automatic logic [25:0] predict_sample(logic [2:0] op, logic [23:0] ph,
                                                   logic [63:0] pos, logic [63:0] seed);
        logic [31:0] p;
        logic [63:0] v, f;
        p = {ph, 8'd0};
        case (op)
            OP_SINE:
            begin
                v = sine_mag(p);
                if (p[31])
                    v = -v;
            end
            OP_SAW:      v = 64'(p >> 7) - 64'd16777216;
            OP_SQUARE:   v = p[31] ? -64'd16777216 : 64'd16777216;
            OP_TRIANGLE:
            begin
                f = 64'(p >> 6);
                v = p[31] ? (64'd50331648 - f) : (f - 64'd16777216);
            end
            OP_NOISE:    v = noise_val(pos, seed);
            default:     v = '0;
        endcase
        return v[25:0];
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall pattern: free-flowing, random, or mostly stalled
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(5, 60);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // output beat scoring
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (samples_due.size() == 0)
            begin
                $error("sample: unexpected beat, actual %h", sample);
                fail_count++;
            end
            else
            begin
                logic [25:0] want;
                want = samples_due.pop_front();
                if (sample !== want)
                begin
                    $error("sample: expected %h actual %h", want, sample);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_beat(logic [2:0] op, logic [23:0] ph, logic [63:0] pos,
                             bit known, logic [25:0] want);
        logic [25:0] model;
        model = predict_sample(op, ph, pos, seed_copy);
        in_valid <= 1'b1;
        opcode   <= op;
        phase    <= ph;
        position <= pos;
        do @(posedge clk); while (!in_ready);
        if (known && model !== want)
        begin
            $error("sample (table): expected %h model %h", want, model);
            fail_count++;
        end
        samples_due.push_back(known ? want : model);
    endtask

    // random gap after a burst ends
    task automatic maybe_gap(inout int burst);
        if (burst > 0)
            burst--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst = $urandom_range(0, 20);
        end
    endtask

    task automatic drain_and_write(logic [63:0] seed);
        in_valid <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_copy  = seed;
    endtask

    stim_row_t directed [] = '{
        '{OP_SINE,     24'h000000, 64'd0, 1, 26'd0},
        '{OP_SINE,     24'h400000, 64'd0, 0, 26'd0},
        '{OP_SINE,     24'h800000, 64'd0, 0, 26'd0},
        '{OP_SINE,     24'hC00000, 64'd0, 0, 26'd0},
        '{OP_SINE,     24'hFFFFFF, 64'd0, 0, 26'd0},
        '{OP_SINE,     24'h200000, 64'd0, 0, 26'd0},
        '{OP_SAW,      24'h000000, 64'd0, 1, MINUS_ONE},
        '{OP_SAW,      24'h800000, 64'd0, 1, 26'd0},
        '{OP_SAW,      24'hFFFFFF, 64'd0, 0, 26'd0},
        '{OP_SQUARE,   24'h000000, 64'd0, 1, PLUS_ONE},
        '{OP_SQUARE,   24'h7FFFFF, 64'd0, 1, PLUS_ONE},
        '{OP_SQUARE,   24'h800000, 64'd0, 1, MINUS_ONE},
        '{OP_SQUARE,   24'hFFFFFF, 64'd0, 1, MINUS_ONE},
        '{OP_TRIANGLE, 24'h000000, 64'd0, 1, MINUS_ONE},
        '{OP_TRIANGLE, 24'h400000, 64'd0, 1, 26'd0},
        '{OP_TRIANGLE, 24'h800000, 64'd0, 1, PLUS_ONE},
        '{OP_TRIANGLE, 24'hFFFFFF, 64'd0, 0, 26'd0},
        '{OP_NOISE,    24'h000000, 64'd0, 0, 26'd0},
        '{OP_NOISE,    24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 26'd0},
        '{OP_NOISE,    24'h123456, 64'd1, 0, 26'd0},
        '{OP_MUTE_LO,  24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 26'd0},
        '{OP_MUTE_MID, 24'h400000, 64'd7, 1, 26'd0},
        '{OP_MUTE_HI,  24'h000000, 64'd0, 1, 26'd0}
    };

    // stimulus
    initial
    begin
        logic [63:0] seeds [4];
        logic [2:0]  op;
        logic [23:0] ph;
        logic [63:0] pos;
        int          burst;
        seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                  {$urandom, $urandom}};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst = 0;
        for (int s = 0; s < 4; s++)
        begin
            drain_and_write(seeds[s]);
            if (s == 0)
                foreach (directed[i])
                begin
                    send_beat(directed[i].op, directed[i].ph, directed[i].pos,
                              directed[i].known, directed[i].want);
                    maybe_gap(burst);
                end
            for (int n = 0; n < RAND_BEATS; n++)
            begin
                op = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 9))
                    0:       ph = 24'h000000;
                    1:       ph = 24'hFFFFFF;
                    2:       ph = {2'($urandom_range(0, 3)), 22'h3FFFFF};
                    default: ph = 24'($urandom);
                endcase
                pos = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 3))
                                                  : {$urandom, $urandom};
                send_beat(op, ph, pos, 0, 26'd0);
                maybe_gap(burst);
            end
        end
        in_valid <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (fail_count == 0 && samples_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
